/* src/sca_pkg.sv */
// ----------------------------------------------------------------------------
// sca_pkg
// shared constants, codes and types of the size class free list allocator
// ----------------------------------------------------------------------------
package sca_pkg;

   // sizing, word size must be a power of two that divides the chunk size
   localparam int WORD_BYTES      = 8;
   localparam int CHUNK_BYTES     = 4 * 1024;
   localparam int MAX_SMALL_BYTES = 128;
   localparam int POOL_CHUNKS     = 16;

   localparam int WORD_LOG2   = $clog2(WORD_BYTES);
   localparam int NUM_CLASSES = MAX_SMALL_BYTES / WORD_BYTES;
   localparam int CHUNK_WORDS = CHUNK_BYTES / WORD_BYTES;
   localparam int LINK_DEPTH  = POOL_CHUNKS * CHUNK_WORDS;

   localparam int SIZE_W      = 32;
   localparam int ADDR_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int WORD_IDX_W  = $clog2(LINK_DEPTH);
   localparam int LINK_W      = $clog2(LINK_DEPTH + 1);
   localparam int SLOT_W      = $clog2(NUM_CLASSES);
   localparam int CLASS_W     = $clog2(NUM_CLASSES + 1);
   localparam int CHUNK_CNT_W = $clog2(POOL_CHUNKS + 1);
   localparam int OFF_W       = $clog2(CHUNK_WORDS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOC     = 2'd0,
      STATUS_FREED     = 2'd1,
      STATUS_OVERSIZED = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   // classified item between front and back
   typedef struct packed {
      mode_type                mode;
      logic                    oversized;
      logic                    block_big;
      logic                    free_ok;
      logic [SLOT_W-1:0]       slot;
      logic [CLASS_W-1:0]      cls;
      logic [WORD_IDX_W-1:0]   free_word;
   } q_entry_type;

   // link store access from the back end
   typedef struct packed {
      logic                    we;
      logic [WORD_IDX_W-1:0]   waddr;
      logic [LINK_W-1:0]       wdata;
      logic                    re;
      logic [WORD_IDX_W-1:0]   raddr;
   } ram_req_type;

endpackage

/* src/sca_ifs.sv */
// ----------------------------------------------------------------------------
// sca request and response channels
// valid/ready channels carrying allocator items
// ----------------------------------------------------------------------------
interface sca_req_if import sca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SIZE_W-1:0]   request_size;
   logic [ADDR_W-1:0]   block_address;

   modport source (output valid, mode, request_size, block_address, input ready);
   modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

interface sca_rsp_if import sca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;

   modport source (output valid, status, granted_address, input ready);
   modport sink   (input valid, status, granted_address, output ready);
endinterface

/* src/size_class_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// segregated free list allocator with word size classes carved from a pool
//
//   channel    direction   carries
//   req_chan   in          mode, request_size, block_address
//   rsp_chan   out         status, granted_address
//
// free, oversized and exhausted items are answered straight from idle in the back end
// allocate from a non-empty list: head check and link store read, then new head and grant
// allocate into an empty class carves a new chunk:
// head check, one link store write per block, then grants the first
// reset clears list heads and chunk count; the link store is not cleared
// a two-entry queue keeps taking requests while a response waits
// ----------------------------------------------------------------------------
module size_class_free_list_allocator import sca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sca_req_if.sink       req_chan,
   sca_rsp_if.source     rsp_chan
);

   logic          q_full;
   logic          q_push;
   q_entry_type   q_entry_in;
   logic          q_valid;
   q_entry_type   q_entry_out;
   logic          q_pop;
   ram_req_type   ram_req;
   logic [LINK_W-1:0] ram_rdata;
   status_type    rsp_status;

   sca_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry_in)
   );

   sca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_entry_in),
      .full      (q_full),
      .valid     (q_valid),
      .entry_out (q_entry_out),
      .pop       (q_pop)
   );

   sca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry_out),
      .q_pop      (q_pop),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_status (rsp_status),
      .rsp_addr   (rsp_chan.granted_address)
   );

   sca_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   assign rsp_chan.status = rsp_status;

endmodule

/* src/sca_ram.sv */
// ----------------------------------------------------------------------------
// sca_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/sca_front.sv */
// ----------------------------------------------------------------------------
// sca_front
// accepts requests and sorts them into size classes
// ----------------------------------------------------------------------------
module sca_front import sca_pkg::*; (
   sca_req_if.sink       req_chan,
   input  logic          q_full,
   output logic          q_push,
   output q_entry_type   q_entry
);

   logic [SIZE_W:0]  size_sum;
   logic [SIZE_W:0]  cls_wide;
   logic [31:0]      word_wide;
   logic [CLASS_W-1:0] cls;

   always_comb begin
      size_sum  = {1'b0, req_chan.request_size} + (SIZE_W + 1)'(WORD_BYTES - 1);
      // size zero still takes one word
      if (req_chan.request_size == '0) begin
         cls_wide = (SIZE_W + 1)'(1);
      end else begin
         cls_wide = size_sum >> WORD_LOG2;
      end
      cls       = cls_wide[CLASS_W-1:0];
      word_wide = 32'(req_chan.block_address) >> WORD_LOG2;

      q_entry.mode      = mode_type'(req_chan.mode);
      q_entry.oversized = cls_wide > (SIZE_W + 1)'(NUM_CLASSES);
      q_entry.block_big = 32'(cls) > 32'(CHUNK_WORDS);
      q_entry.free_ok   = word_wide < 32'(LINK_DEPTH);
      q_entry.slot      = SLOT_W'(cls - CLASS_W'(1));
      q_entry.cls       = cls;
      q_entry.free_word = word_wide[WORD_IDX_W-1:0];
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

endmodule

/* src/sca_queue.sv */
// ----------------------------------------------------------------------------
// sca_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module sca_queue import sca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  q_entry_type   entry_in,
   output logic          full,
   output logic          valid,
   output q_entry_type   entry_out,
   input  logic          pop
);

   q_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign valid     = count_ff != '0;
   assign entry_out = mem_ff[rd_ptr_ff];

endmodule

/* src/sca_back.sv */
// ----------------------------------------------------------------------------
// sca_back
// runs free list pops, pushes and chunk carving, holds the response register
// ----------------------------------------------------------------------------
module sca_back import sca_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  q_entry_type           q_entry,
   output logic                  q_pop,
   output ram_req_type           ram_req,
   input  logic [LINK_W-1:0]     ram_rdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output status_type            rsp_status,
   output logic [ADDR_W-1:0]     rsp_addr
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LINK,
      S_CARVE
   } state_type;

   state_type                 state_ff, state_in;
   logic [LINK_W-1:0]         heads_ff [NUM_CLASSES];
   logic [LINK_W-1:0]         heads_in [NUM_CLASSES];
   logic [CHUNK_CNT_W-1:0]    chunk_ff, chunk_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [CLASS_W-1:0]        cls_ff, cls_in;
   logic [WORD_IDX_W-1:0]     base_ff, base_in;
   logic [OFF_W-1:0]          off_ff, off_in;
   logic [WORD_IDX_W-1:0]     hword_ff, hword_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;

   logic [LINK_W-1:0]         head_cur;
   logic                      out_free;
   logic                      carve_more;
   logic [LINK_W-1:0]         carve_next;
   logic [LINK_W-1:0]         carve_head;

   always_comb begin
      head_cur   = heads_ff[q_entry.slot];
      out_free   = !rsp_valid_ff || rsp_ready;
      carve_more = (32'(off_ff) + 32'(cls_ff) + 32'(cls_ff)) <= 32'(CHUNK_WORDS);
      carve_next = carve_more ?
                   LINK_W'(32'(base_ff) + 32'(off_ff) + 32'(cls_ff) + 32'd1) : '0;
      carve_head = ((32'(cls_ff) + 32'(cls_ff)) <= 32'(CHUNK_WORDS)) ?
                   LINK_W'(32'(base_ff) + 32'(cls_ff) + 32'd1) : '0;

      state_in      = state_ff;
      heads_in      = heads_ff;
      chunk_in      = chunk_ff;
      slot_in       = slot_ff;
      cls_in        = cls_ff;
      base_in       = base_ff;
      off_in        = off_ff;
      hword_in      = hword_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      q_pop         = 1'b0;
      ram_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               priority if (q_entry.oversized) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OVERSIZED;
                  rsp_addr_in   = '0;
               end else if (q_entry.mode == MODE_FREE) begin
                  if (q_entry.free_ok) begin
                     ram_req.we              = 1'b1;
                     ram_req.waddr           = q_entry.free_word;
                     ram_req.wdata           = head_cur;
                     heads_in[q_entry.slot]  = LINK_W'(q_entry.free_word) + LINK_W'(1);
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FREED;
                  rsp_addr_in   = '0;
               end else if (head_cur != '0) begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = WORD_IDX_W'(head_cur - LINK_W'(1));
                  hword_in      = WORD_IDX_W'(head_cur - LINK_W'(1));
                  slot_in       = q_entry.slot;
                  state_in      = S_LINK;
               end else if (q_entry.block_big) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OVERSIZED;
                  rsp_addr_in   = '0;
               end else if (32'(chunk_ff) >= 32'(POOL_CHUNKS)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EXHAUSTED;
                  rsp_addr_in   = '0;
               end else begin
                  slot_in  = q_entry.slot;
                  cls_in   = q_entry.cls;
                  base_in  = WORD_IDX_W'(32'(chunk_ff) * 32'(CHUNK_WORDS));
                  off_in   = '0;
                  state_in = S_CARVE;
               end
            end
         end
         S_LINK: begin
            heads_in[slot_ff] = ram_rdata;
            rsp_valid_in      = 1'b1;
            rsp_status_in     = STATUS_ALLOC;
            rsp_addr_in       = ADDR_W'(32'(hword_ff) << WORD_LOG2);
            state_in          = S_IDLE;
         end
         S_CARVE: begin
            // one block link per cycle, address order
            ram_req.we    = 1'b1;
            ram_req.waddr = WORD_IDX_W'(32'(base_ff) + 32'(off_ff));
            ram_req.wdata = carve_next;
            if (carve_more) begin
               off_in = off_ff + OFF_W'(cls_ff);
            end else begin
               heads_in[slot_ff] = carve_head;
               chunk_in          = chunk_ff + CHUNK_CNT_W'(1);
               rsp_valid_in      = 1'b1;
               rsp_status_in     = STATUS_ALLOC;
               rsp_addr_in       = ADDR_W'(32'(base_ff) << WORD_LOG2);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      slot_ff       <= slot_in;
      cls_ff        <= cls_in;
      base_ff       <= base_in;
      off_ff        <= off_in;
      hword_ff      <= hword_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;

endmodule

/* src/sca_checker.sv */
// ----------------------------------------------------------------------------
// sca_checker
// port level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
module sca_checker import sca_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [ADDR_W-1:0]     rsp_granted_address
);

   logic [3:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   always_comb begin
      req_take = req_valid && req_ready;
      rsp_take = rsp_valid && rsp_ready;
      pend_in  = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pend_in = pend_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no response without an item in flight
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("response without pending item");

   // only a grant carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FREED || rsp_status == STATUS_OVERSIZED ||
                    rsp_status == STATUS_EXHAUSTED) |-> rsp_granted_address == '0)
      else $error("nonzero address on non-grant response");

   // granted blocks are word aligned
   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ALLOC |->
         (rsp_granted_address & ADDR_W'(WORD_BYTES - 1)) == '0)
      else $error("misaligned grant");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_granted_address))
      else $error("stalled response changed");

endmodule

bind size_class_free_list_allocator sca_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_granted_address (rsp_chan.granted_address)
);
